@@ rtl/core/mrl_pkg.sv @@
// mrl_pkg: types, register indexes and constants of the measurement ring log
// used by every module in rtl/core; depends on nothing else
package mrl_pkg;

	localparam int DEF_LOG_DEPTH = 64;

	localparam int POS_W     = 6;
	localparam int CNT_OUT_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 63;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PART_LIMIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_METRIC_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_LIMIT     = 3'd5;

	localparam logic [62:0] RST_THRESHOLD      = 63'd1680000000;
	localparam logic [6:0]  RST_RESOURCE_LIMIT = 7'd64;
	localparam logic [12:0] RST_PART_LIMIT     = 13'd4096;
	localparam logic [12:0] RST_METRIC_LIMIT   = 13'd4096;
	localparam logic [8:0]  RST_UNIT_LIMIT     = 9'd256;

	typedef struct packed {
		logic        queue_mode;
		logic [62:0] time_threshold;
		logic [6:0]  resource_limit;
		logic [12:0] part_limit;
		logic [12:0] metric_limit;
		logic [8:0]  unit_limit;
	} cfg_t;

	// stored entry, path without its tag byte
	typedef struct packed {
		logic [63:0] node;
		logic [55:0] path;
		logic [63:0] addr;
		logic [63:0] time_bits;
		logic [31:0] sample;
	} entry_t;

	// result control from the sequencer to the output stage
	typedef struct packed {
		logic done;
		logic read;
		logic ok;
		logic full;
	} res_ctl_t;

endpackage

@@ rtl/core/mrl_cfg.sv @@
// mrl_cfg: configuration registers written through the plain write port
// depends on mrl_pkg
module mrl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mrl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mrl_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output mrl_pkg::cfg_t                  cfg
);
	import mrl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_mode     <= 1'b0;
			cfg_q.time_threshold <= RST_THRESHOLD;
			cfg_q.resource_limit <= RST_RESOURCE_LIMIT;
			cfg_q.part_limit     <= RST_PART_LIMIT;
			cfg_q.metric_limit   <= RST_METRIC_LIMIT;
			cfg_q.unit_limit     <= RST_UNIT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QUEUE_MODE:     cfg_q.queue_mode     <= cfg_wdata[0];
				REG_TIME_THRESHOLD: cfg_q.time_threshold <= cfg_wdata[62:0];
				REG_RESOURCE_LIMIT: cfg_q.resource_limit <= cfg_wdata[6:0];
				REG_PART_LIMIT:     cfg_q.part_limit     <= cfg_wdata[12:0];
				REG_METRIC_LIMIT:   cfg_q.metric_limit   <= cfg_wdata[12:0];
				REG_UNIT_LIMIT:     cfg_q.unit_limit     <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/mrl_entry_ram.sv @@
// mrl_entry_ram: entry memory, one write and one registered read per cycle
// depends on mrl_pkg for the entry type
module mrl_entry_ram #(
	parameter int DEPTH = mrl_pkg::DEF_LOG_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  mrl_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output mrl_pkg::entry_t rd_data
);
	import mrl_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/core/mrl_ctrl.sv @@
// mrl_ctrl: append checks, write pointer, wrap flag and read address
// depends on mrl_pkg; drives the entry memory and the result stage
module mrl_ctrl #(
	parameter int LOG_DEPTH = mrl_pkg::DEF_LOG_DEPTH,
	parameter int PTR_W     = $clog2(LOG_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          func,
	input  logic [63:0]                   node_id,
	input  logic [63:0]                   packed_path,
	input  logic [63:0]                   device_addr,
	input  logic [63:0]                   time_stamp,
	input  logic [31:0]                   sample_bits,
	input  logic [mrl_pkg::POS_W-1:0]     position,
	input  mrl_pkg::cfg_t                 cfg,
	output logic                          wr_en,
	output logic [PTR_W-1:0]              wr_addr,
	output mrl_pkg::entry_t               wr_data,
	output logic                          rd_en,
	output logic [PTR_W-1:0]              rd_addr,
	output mrl_pkg::res_ctl_t             ctl,
	output logic [mrl_pkg::CNT_OUT_W-1:0] stored_count
);
	import mrl_pkg::*;

	localparam int CW = PTR_W + 1;
	localparam int SW = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
	localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	logic [PTR_W-1:0] wp_q, wp_d;
	logic             wrapped_q, wrapped_d;
	logic             done_s1, read_s1, ok_s1, full_s1;
	logic [CW-1:0]    count_s1;

	logic          is_read, ts_valid, range_ok, mode_ok, app_ok, hit;
	logic [CW-1:0] cnt_now, cnt_next;
	logic [SW-1:0] pos_x, sum, sum_adj;
	logic [XW-1:0] cnt_x;

	always_comb begin
		is_read  = (func == FUNC_READ);
		ts_valid = !time_stamp[63] && (time_stamp[62:0] > cfg.time_threshold);
		range_ok = ({1'b0, packed_path[13:8]} < cfg.resource_limit)
		        && ({1'b0, packed_path[35:24]} < cfg.part_limit)
		        && ({1'b0, packed_path[55:44]} < cfg.metric_limit)
		        && ({1'b0, packed_path[63:56]} < cfg.unit_limit);
		mode_ok  = (cfg.queue_mode || !wrapped_q) && (!cfg.queue_mode || ts_valid);
		app_ok   = accept && !is_read && mode_ok && range_ok;

		wr_en             = app_ok;
		wr_addr           = wp_q;
		wr_data.node      = node_id;
		wr_data.path      = packed_path[63:8];
		wr_data.addr      = device_addr;
		wr_data.time_bits = ts_valid ? time_stamp : 64'd0;
		wr_data.sample    = sample_bits;

		wp_d      = wp_q;
		wrapped_d = wrapped_q;
		if (app_ok) begin
			if (wp_q == PTR_W'(LOG_DEPTH - 1)) begin
				wp_d      = '0;
				wrapped_d = 1'b1;
			end else begin
				wp_d = wp_q + 1'b1;
			end
		end

		cnt_now  = wrapped_q ? CW'(LOG_DEPTH) : {1'b0, wp_q};
		cnt_next = wrapped_d ? CW'(LOG_DEPTH) : {1'b0, wp_d};

		// oldest entry sits at the write pointer once wrapped
		pos_x   = SW'(position);
		sum     = SW'(wp_q) + pos_x;
		sum_adj = (sum >= SW'(LOG_DEPTH)) ? (sum - SW'(LOG_DEPTH)) : sum;
		hit     = pos_x < SW'(cnt_now);
		rd_en   = accept && is_read;
		rd_addr = wrapped_q ? sum_adj[PTR_W-1:0] : pos_x[PTR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			done_s1   <= 1'b0;
			read_s1   <= 1'b0;
			ok_s1     <= 1'b0;
			full_s1   <= 1'b0;
			count_s1  <= '0;
		end else begin
			wp_q      <= wp_d;
			wrapped_q <= wrapped_d;
			done_s1   <= accept;
			if (accept) begin
				read_s1  <= is_read;
				ok_s1    <= is_read ? hit : app_ok;
				full_s1  <= wrapped_d;
				count_s1 <= cnt_next;
			end
		end
	end

	always_comb begin
		ctl.done     = done_s1;
		ctl.read     = read_s1;
		ctl.ok       = ok_s1;
		ctl.full     = full_s1;
		cnt_x        = XW'(count_s1);
		stored_count = cnt_x[CNT_OUT_W-1:0];
	end

endmodule

@@ rtl/core/measurement_ring_log_core.sv @@
// measurement_ring_log_core: top level of the measurement ring log
// depends on mrl_pkg, mrl_cfg, mrl_ctrl and mrl_entry_ram
//
// A command is taken at every clock edge where start is high and busy is low;
// busy stays low, so one append or read enters each cycle. Its result word
// appears in the next cycle with done high for exactly that cycle and cannot be
// held off. The read data comes from the registered read port of the entry
// memory; appends write the memory at the edge that takes them, so a read in
// the next cycle already sees the new entry. Entries live in a LOG_DEPTH-deep
// synchronous memory with no clearing pass; reads only reach written entries.
module measurement_ring_log_core #(
	parameter int LOG_DEPTH = mrl_pkg::DEF_LOG_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mrl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mrl_pkg::CFG_DAT_W-1:0] cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [63:0]                    node_id,
	input  logic [63:0]                    packed_path,
	input  logic [63:0]                    device_addr,
	input  logic signed [63:0]             time_stamp,
	input  logic [31:0]                    sample_bits,
	input  logic [mrl_pkg::POS_W-1:0]      position,
	output logic                           done,
	output logic                           accepted,
	output logic [63:0]                    out_node,
	output logic [63:0]                    out_path,
	output logic [63:0]                    out_addr,
	output logic signed [63:0]             out_time,
	output logic [31:0]                    out_sample,
	output logic [mrl_pkg::CNT_OUT_W-1:0]  stored_count,
	output logic                           is_full
);
	import mrl_pkg::*;

	localparam int PTR_W = $clog2(LOG_DEPTH);

	cfg_t             cfg;
	res_ctl_t         ctl;
	entry_t           wr_data, rd_data;
	logic             wr_en, rd_en, accept;
	logic [PTR_W-1:0] wr_addr, rd_addr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	mrl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mrl_ctrl #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.node_id      (node_id),
		.packed_path  (packed_path),
		.device_addr  (device_addr),
		.time_stamp   (time_stamp),
		.sample_bits  (sample_bits),
		.position     (position),
		.cfg          (cfg),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.ctl          (ctl),
		.stored_count (stored_count)
	);

	mrl_entry_ram #(
		.DEPTH (LOG_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		done       = ctl.done;
		accepted   = ctl.ok;
		is_full    = ctl.full;
		out_node   = 64'd0;
		out_path   = 64'd0;
		out_addr   = 64'd0;
		out_time   = 64'sd0;
		out_sample = 32'd0;
		if (ctl.read && ctl.ok) begin
			out_node   = rd_data.node;
			out_path   = {rd_data.path, rd_data.node[7:0]};
			out_addr   = rd_data.addr;
			out_time   = rd_data.time_bits;
			out_sample = rd_data.sample;
		end
	end

	// a result word only follows a command taken in the cycle before
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result word without a command");

	// the wrap flag never clears outside reset
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !$fell(is_full))
		else $error("full flag dropped");

	// a refused command leaves fill level and wrap flag unchanged
	a_refused_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted && $past(done) |->
		stored_count == $past(stored_count) && is_full == $past(is_full))
		else $error("refused command changed the log");

endmodule
